/* rtl/core/dqp_pkg.sv */
// dqp_pkg: shared types and constants for the dns query parser core
// no dependencies; imported by every module of the core

package dqp_pkg;

    localparam int MAX_NAME_CHARS_DEF = 256;
    localparam int HEADER_BYTES       = 12;
    localparam int TYPE_CLASS_BYTES   = 4;
    localparam int HDR_WORDS          = 5;
    localparam int CMP_W              = 17;

    localparam int W_ID        = 0;
    localparam int W_FLAGS     = 1;
    localparam int W_QUESTIONS = 2;
    localparam int W_ANSWERS   = 3;
    localparam int W_AUTHORITY = 4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ANSWERS   = 3'd1;
    localparam logic [2:0] ST_AUTHORITY = 3'd2;
    localparam logic [2:0] ST_QCOUNT    = 3'd3;
    localparam logic [2:0] ST_NAME_BAD  = 3'd4;
    localparam logic [2:0] ST_NO_ROOM   = 3'd5;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic [7:0] DOT_CHAR = 8'h2e;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic [15:0] message_length;
        logic        last_byte;
    } query_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  name_char;
        logic [2:0]  status;
        logic [15:0] query_id;
        logic [15:0] header_flags;
        logic [15:0] question_type;
        logic [15:0] question_class;
    } result_t;

    typedef struct packed {
        logic    hit;
        result_t res;
    } step_t;

endpackage

/* rtl/core/dqp_in_stage.sv */
// dqp_in_stage: input register of the parser core
// depends on dqp_pkg

module dqp_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           query_valid,
    output logic           query_stall,
    input  dqp_pkg::query_t query,
    input  logic           room,
    output logic           fire,
    output dqp_pkg::query_t held
);
    import dqp_pkg::*;

    logic   valid_reg;
    query_t query_reg;

    assign query_stall = valid_reg && !room;
    assign fire        = valid_reg && room;
    assign held        = query_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!query_stall)
        begin
            valid_reg <= query_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_valid && !query_stall)
        begin
            query_reg <= query;
        end
    end

endmodule

/* rtl/core/dqp_parse.sv */
// dqp_parse: message state and per-byte decode of header, name and type/class
// depends on dqp_pkg

module dqp_parse #(
    parameter int MAX_NAME_CHARS = dqp_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  dqp_pkg::query_t query,
    output dqp_pkg::step_t  step
);
    import dqp_pkg::*;

    localparam int NI_W = $clog2(MAX_NAME_CHARS);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME_LEN,
        PH_NAME_CHARS,
        PH_TYPE_CLASS,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] hdr_reg [HDR_WORDS];
    logic [15:0] hdr_next [HDR_WORDS];
    logic [NI_W-1:0] name_idx_reg, name_idx_next;
    logic [7:0]  rem_reg, rem_next;
    logic [31:0] shift_reg, shift_next;

    logic        hit;
    result_t     res;
    logic [2:0]  hdr_sel;
    logic        dot;
    logic [CMP_W-1:0] j_sum;
    logic [CMP_W-1:0] len_sum;
    logic        bad;
    logic [2:0]  hdr_status;

    function automatic result_t make_record(
        input logic [2:0]  st,
        input logic [15:0] id,
        input logic [15:0] flags,
        input logic [15:0] qt,
        input logic [15:0] qc
    );
        result_t r;
        r.out_kind       = KIND_RECORD;
        r.name_char      = '0;
        r.status         = st;
        r.query_id       = id;
        r.header_flags   = flags;
        r.question_type  = qt;
        r.question_class = qc;
        return r;
    endfunction

    function automatic result_t make_char(input logic [7:0] c);
        result_t r;
        r           = '0;
        r.out_kind  = KIND_CHAR;
        r.name_char = c;
        return r;
    endfunction

    assign hdr_sel = pos_reg[3:1];
    assign dot     = (name_idx_reg != '0);
    assign j_sum   = CMP_W'(name_idx_reg) + CMP_W'(dot);
    assign len_sum = j_sum + CMP_W'(query.in_byte);
    assign bad     = (len_sum >= CMP_W'(MAX_NAME_CHARS))
                  || ((query.message_length >= 16'(HEADER_BYTES))
                      && (len_sum >= CMP_W'(query.message_length - 16'(HEADER_BYTES))));

    always_comb
    begin
        if (hdr_reg[W_ANSWERS] != '0)
        begin
            hdr_status = ST_ANSWERS;
        end
        else if (hdr_reg[W_AUTHORITY] != '0)
        begin
            hdr_status = ST_AUTHORITY;
        end
        else if (hdr_reg[W_QUESTIONS] != 16'd1)
        begin
            hdr_status = ST_QCOUNT;
        end
        else
        begin
            hdr_status = ST_OK;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_next      = hdr_reg;
        name_idx_next = name_idx_reg;
        rem_next      = rem_reg;
        shift_next    = shift_reg;
        hit           = 1'b0;
        res           = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (hdr_sel < 3'(HDR_WORDS))
                begin
                    hdr_next[hdr_sel] = {hdr_reg[hdr_sel][7:0], query.in_byte};
                end
                if (pos_reg >= 16'(HEADER_BYTES - 1))
                begin
                    if (hdr_status != ST_OK)
                    begin
                        hit        = 1'b1;
                        res        = make_record(hdr_status, hdr_next[W_ID],
                                                 hdr_next[W_FLAGS], '0, '0);
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next    = PH_NAME_LEN;
                        name_idx_next = '0;
                    end
                end
            end
            PH_NAME_LEN:
            begin
                if (query.in_byte == '0)
                begin
                    if (CMP_W'(query.message_length)
                        < CMP_W'(pos_reg) + CMP_W'(TYPE_CLASS_BYTES + 1))
                    begin
                        hit        = 1'b1;
                        res        = make_record(ST_NO_ROOM, hdr_reg[W_ID],
                                                 hdr_reg[W_FLAGS], '0, '0);
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_TYPE_CLASS;
                        rem_next   = 8'(TYPE_CLASS_BYTES);
                        shift_next = '0;
                    end
                end
                else if (bad)
                begin
                    hit        = 1'b1;
                    res        = make_record(ST_NAME_BAD, hdr_reg[W_ID],
                                             hdr_reg[W_FLAGS], '0, '0);
                    phase_next = PH_DONE;
                end
                else
                begin
                    name_idx_next = j_sum[NI_W-1:0];
                    rem_next      = query.in_byte;
                    phase_next    = PH_NAME_CHARS;
                    if (dot)
                    begin
                        hit = 1'b1;
                        res = make_char(DOT_CHAR);
                    end
                end
            end
            PH_NAME_CHARS:
            begin
                hit           = 1'b1;
                res           = make_char(query.in_byte);
                name_idx_next = name_idx_reg + NI_W'(1);
                rem_next      = rem_reg - 8'd1;
                if (rem_reg == 8'd1)
                begin
                    phase_next = PH_NAME_LEN;
                end
            end
            PH_TYPE_CLASS:
            begin
                shift_next = {shift_reg[23:0], query.in_byte};
                rem_next   = rem_reg - 8'd1;
                if (rem_reg == 8'd1)
                begin
                    hit        = 1'b1;
                    res        = make_record(ST_OK, hdr_reg[W_ID], hdr_reg[W_FLAGS],
                                             shift_next[31:16], shift_next[15:0]);
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        pos_next = (pos_reg != 16'hffff) ? pos_reg + 16'd1 : pos_reg;

        if (query.last_byte)
        begin
            if (phase_next != PH_DONE)
            begin
                hit = 1'b1;
                res = make_record(ST_NO_ROOM, hdr_next[W_ID], hdr_next[W_FLAGS], '0, '0);
            end
            phase_next    = PH_HEADER;
            pos_next      = '0;
            name_idx_next = '0;
            rem_next      = '0;
            shift_next    = '0;
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                hdr_next[i] = '0;
            end
        end
    end

    assign step = {fire && hit, res};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            name_idx_reg <= '0;
            rem_reg      <= '0;
            shift_reg    <= '0;
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            name_idx_reg <= name_idx_next;
            rem_reg      <= rem_next;
            shift_reg    <= shift_next;
            for (int i = 0; i < HDR_WORDS; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule

/* rtl/core/dqp_out_stage.sv */
// dqp_out_stage: result register of the parser core
// depends on dqp_pkg

module dqp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  dqp_pkg::step_t   step,
    output logic             room,
    output logic             result_valid,
    input  logic             result_stall,
    output dqp_pkg::result_t result
);
    import dqp_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign room         = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= step.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && step.hit)
        begin
            result_reg <= step.res;
        end
    end

endmodule

/* rtl/core/dns_query_parser_core.sv */
// dns_query_parser_core: top level of the streaming dns query parser
// depends on dqp_pkg, dqp_in_stage, dqp_parse, dqp_out_stage
//
// Takes one message byte per cycle and, through the input register and then
// the result register, gives one name character, one final record or nothing
// for that byte. A byte's decode is a single pass of position and phase logic
// between the two registers, so a new byte is taken every cycle while results
// are taken; the parse state carries from one byte to the next
// and returns to the header phase after the byte marked last. The core holds
// off input only while a finished result waits under stall and the input
// register is full. MAX_NAME_CHARS sets the longest decoded name.

module dns_query_parser_core #(
    parameter int MAX_NAME_CHARS = dqp_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  dqp_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_stall,
    output dqp_pkg::result_t result
);
    import dqp_pkg::*;

    logic   room;
    logic   fire;
    query_t held;
    step_t  step;

    dqp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_stall (query_stall),
        .query       (query),
        .room        (room),
        .fire        (fire),
        .held        (held)
    );

    dqp_parse #(
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .query (held),
        .step  (step)
    );

    dqp_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* rtl/core/dqp_checker.sv */
// dqp_checker: port-level assertions for dns_query_parser_core
// depends on dqp_pkg; bound to the top level below

module dqp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             query_stall,
    input logic             result_valid,
    input logic             result_stall,
    input dqp_pkg::result_t result
);
    import dqp_pkg::*;

    // stalled result transfer holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed under stall");

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> result_valid && result_stall)
        else $error("input stalled without blocked result");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind == KIND_CHAR |->
            result.status == ST_OK && result.query_id == '0 && result.header_flags == '0
            && result.question_type == '0 && result.question_class == '0)
        else $error("name character carries record fields");

    a_record_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind == KIND_RECORD |->
            result.name_char == '0 && result.status <= ST_NO_ROOM)
        else $error("malformed final record");

    a_fail_no_type: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_kind == KIND_RECORD && result.status != ST_OK |->
            result.question_type == '0 && result.question_class == '0)
        else $error("failed record carries type or class");

endmodule

bind dns_query_parser_core dqp_checker u_dqp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_stall  (query_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* test/dns_query_parser_core_tb.sv */
// dns_query_parser_core_tb: self-checking bench for the streaming dns query parser core
// drives whole query messages byte by byte and predicts every name character and final record
// depends on dqp_pkg and dns_query_parser_core
`timescale 1ns / 100ps

module dns_query_parser_core_tb;

    import dqp_pkg::*;

    localparam int NAME_LIMIT   = MAX_NAME_CHARS_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CALM_ITEMS   = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int PRINT_CAP    = 40;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME_LEN,
        PH_NAME_CHARS,
        PH_TYPE_CLASS,
        PH_DONE
    } parse_phase_t;

    logic    clk;
    logic    rst_n;
    logic    query_valid = 1'b0;
    logic    query_stall;
    query_t  query = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    dns_query_parser_core #(
        .MAX_NAME_CHARS(NAME_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .query_valid(query_valid),
        .query_stall(query_stall),
        .query(query),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    // parser state of the predictor
    logic [15:0]  byte_pos;
    parse_phase_t phase;
    logic [15:0]  hdr_word [6];
    int           name_idx;
    logic [7:0]   label_left;
    logic [31:0]  tc_shift;
    bit           record_sent;

    query_t     pending_bytes [$];
    result_t    expected_results [$];
    logic [7:0] msg_bytes [$];
    result_t    want;

    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int queued_items = 0;
    int messages_queued = 0;
    int chars_seen = 0;
    int records_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        if (mismatches < PRINT_CAP)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_val, $time);
        mismatches++;
    endtask

    task automatic clear_parser();
        byte_pos    = '0;
        phase       = PH_HEADER;
        for (int i = 0; i < 6; i++)
            hdr_word[i] = '0;
        name_idx    = 0;
        label_left  = '0;
        tc_shift    = '0;
        record_sent = 1'b0;
    endtask

    function automatic result_t make_record(input logic [2:0] st, input logic [15:0] qtype,
                                            input logic [15:0] qclass);
        result_t r;
        r                = '0;
        r.out_kind       = KIND_RECORD;
        r.status         = st;
        r.query_id       = hdr_word[W_ID];
        r.header_flags   = hdr_word[W_FLAGS];
        r.question_type  = qtype;
        r.question_class = qclass;
        return r;
    endfunction

    function automatic result_t make_char(input logic [7:0] c);
        result_t r;
        r           = '0;
        r.out_kind  = KIND_CHAR;
        r.name_char = c;
        return r;
    endfunction

    task automatic decode_byte(input query_t q);
        result_t    r;
        bit         hit;
        bit         dot;
        int         w;
        int         j;
        int         ml;
        logic [2:0] st;
        r   = '0;
        hit = 1'b0;
        ml  = int'(q.message_length);
        if (!record_sent)
        begin
            case (phase)
                PH_HEADER:
                begin
                    w = (int'(byte_pos) >> 1) % 6;
                    hdr_word[w] = {hdr_word[w][7:0], q.in_byte};
                    if (byte_pos >= HEADER_BYTES - 1)
                    begin
                        st = ST_OK;
                        if (hdr_word[W_ANSWERS] != 0)
                            st = ST_ANSWERS;
                        else if (hdr_word[W_AUTHORITY] != 0)
                            st = ST_AUTHORITY;
                        else if (hdr_word[W_QUESTIONS] != 1)
                            st = ST_QCOUNT;
                        if (st != ST_OK)
                        begin
                            r           = make_record(st, '0, '0);
                            hit         = 1'b1;
                            record_sent = 1'b1;
                            phase       = PH_DONE;
                        end
                        else
                        begin
                            phase    = PH_NAME_LEN;
                            name_idx = 0;
                        end
                    end
                end
                PH_NAME_LEN:
                begin
                    if (q.in_byte == 0)
                    begin
                        if (ml - int'(byte_pos) - 1 < TYPE_CLASS_BYTES)
                        begin
                            r           = make_record(ST_NO_ROOM, '0, '0);
                            hit         = 1'b1;
                            record_sent = 1'b1;
                            phase       = PH_DONE;
                        end
                        else
                        begin
                            phase      = PH_TYPE_CLASS;
                            label_left = 8'(TYPE_CLASS_BYTES);
                            tc_shift   = '0;
                        end
                    end
                    else
                    begin
                        dot = (name_idx != 0);
                        j   = name_idx + (dot ? 1 : 0);
                        if ((j + int'(q.in_byte) >= NAME_LIMIT) ||
                            (ml >= HEADER_BYTES && j + int'(q.in_byte) >= ml - HEADER_BYTES))
                        begin
                            r           = make_record(ST_NAME_BAD, '0, '0);
                            hit         = 1'b1;
                            record_sent = 1'b1;
                            phase       = PH_DONE;
                        end
                        else
                        begin
                            name_idx   = j;
                            label_left = q.in_byte;
                            phase      = PH_NAME_CHARS;
                            if (dot)
                            begin
                                r   = make_char(DOT_CHAR);
                                hit = 1'b1;
                            end
                        end
                    end
                end
                PH_NAME_CHARS:
                begin
                    r          = make_char(q.in_byte);
                    hit        = 1'b1;
                    name_idx   = name_idx + 1;
                    label_left = label_left - 1;
                    if (label_left == 0)
                        phase = PH_NAME_LEN;
                end
                PH_TYPE_CLASS:
                begin
                    tc_shift   = {tc_shift[23:0], q.in_byte};
                    label_left = label_left - 1;
                    if (label_left == 0)
                    begin
                        r           = make_record(ST_OK, tc_shift[31:16], tc_shift[15:0]);
                        hit         = 1'b1;
                        record_sent = 1'b1;
                        phase       = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (byte_pos != 16'hFFFF)
            byte_pos = byte_pos + 1;
        if (q.last_byte)
        begin
            if (!record_sent)
            begin
                r   = make_record(ST_NO_ROOM, '0, '0);
                hit = 1'b1;
            end
            clear_parser();
        end
        if (hit)
            expected_results.push_back(r);
    endtask

    task automatic put_word(input logic [15:0] w);
        msg_bytes.push_back(w[15:8]);
        msg_bytes.push_back(w[7:0]);
    endtask

    task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an,
                              input logic [15:0] ns);
        put_word(id);
        put_word(flags);
        put_word(qd);
        put_word(an);
        put_word(ns);
        put_word(16'($urandom_range(0, 65535)));
    endtask

    task automatic put_label(input int len);
        msg_bytes.push_back(8'(len));
        repeat (len)
            msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_query(input logic [15:0] id, input logic [15:0] flags,
                               input logic [15:0] qd, input logic [15:0] an,
                               input logic [15:0] ns, input int labels, input int max_len,
                               input logic [15:0] qtype, input logic [15:0] qclass,
                               input int trail);
        put_header(id, flags, qd, an, ns);
        for (int i = 0; i < labels; i++)
            put_label($urandom_range(1, max_len));
        msg_bytes.push_back(8'h00);
        put_word(qtype);
        put_word(qclass);
        repeat (trail)
            msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // cut below 1 keeps the whole message; last_byte marks the final byte kept
    task automatic queue_message(input int ml, input int cut);
        query_t item;
        int     n;
        n = (cut >= 1 && cut < msg_bytes.size()) ? cut : msg_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            item.in_byte        = msg_bytes[i];
            item.message_length = 16'(ml);
            item.last_byte      = (i == n - 1);
            pending_bytes.push_back(item);
        end
        queued_items += n;
        messages_queued++;
        msg_bytes.delete();
    endtask

    function automatic logic [15:0] rand_word();
        return 16'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int kind;
        int ml;
        int random_end;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] ns;

        rst_n = 1'b0;
        clear_parser();

        // root name and a three-label name, extreme header and type/class values, exact length
        build_query(16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 1, 16'hFFFF, 16'hFFFF, 0);
        queue_message(msg_bytes.size(), 0);
        build_query(16'h0000, 16'h0000, 1, 0, 0, 3, 12, 16'h0000, 16'h0000, 3);
        queue_message(msg_bytes.size(), 0);
        // count checks in priority order
        build_query(rand_word(), rand_word(), 0, 16'hFFFF, 1, 1, 5, rand_word(), rand_word(), 0);
        queue_message(msg_bytes.size(), 0);
        build_query(rand_word(), rand_word(), 2, 0, 16'h8000, 1, 5, rand_word(), rand_word(), 0);
        queue_message(msg_bytes.size(), 0);
        build_query(rand_word(), rand_word(), 16'hFFFF, 0, 0, 1, 5, rand_word(), rand_word(), 0);
        queue_message(msg_bytes.size(), HEADER_BYTES);
        // name longer than the message allows
        build_query(rand_word(), rand_word(), 1, 0, 0, 2, 8, rand_word(), rand_word(), 0);
        queue_message(HEADER_BYTES + 1, 0);
        // name limit with the length comparison skipped
        put_header(rand_word(), rand_word(), 1, 0, 0);
        put_label(255);
        put_label(1);
        msg_bytes.push_back(8'h00);
        put_word(rand_word());
        put_word(rand_word());
        queue_message(5, 0);
        // no room for type and class
        build_query(rand_word(), rand_word(), 1, 0, 0, 0, 1, rand_word(), rand_word(), 0);
        queue_message(11, 0);
        build_query(rand_word(), rand_word(), 1, 0, 0, 0, 1, rand_word(), rand_word(), 0);
        queue_message(msg_bytes.size() - 1, 0);
        // early ends: in the header, on a name character, inside type/class
        build_query(rand_word(), rand_word(), 1, 0, 0, 1, 5, rand_word(), rand_word(), 0);
        queue_message(msg_bytes.size(), 5);
        put_header(rand_word(), rand_word(), 1, 0, 0);
        put_label(5);
        msg_bytes.push_back(8'h00);
        put_word(rand_word());
        put_word(rand_word());
        queue_message(msg_bytes.size(), HEADER_BYTES + 4);
        build_query(rand_word(), rand_word(), 1, 0, 0, 0, 1, rand_word(), rand_word(), 0);
        queue_message(msg_bytes.size(), HEADER_BYTES + 3);
        // single byte message
        msg_bytes.push_back(8'($urandom_range(0, 255)));
        queue_message(0, 0);
        // largest message length with trailing bytes
        build_query(rand_word(), rand_word(), 1, 0, 0, 2, 12, rand_word(), rand_word(), 6);
        queue_message(65535, 0);

        random_end = RANDOM_ITEMS;
        while (queued_items < random_end)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                build_query(rand_word(), rand_word(), 1, 0, 0, $urandom_range(0, 4),
                            ($urandom_range(0, 9) == 0) ? 63 : 12, rand_word(), rand_word(),
                            ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6));
                case ($urandom_range(0, 9))
                    0, 1:    ml = $urandom_range(msg_bytes.size(), 65535);
                    2:       ml = msg_bytes.size() - $urandom_range(1, 6);
                    default: ml = msg_bytes.size();
                endcase
                queue_message(ml, ($urandom_range(0, 9) == 0) ?
                                  $urandom_range(1, msg_bytes.size()) : 0);
            end
            else if (kind == 6)
            begin
                case ($urandom_range(0, 3))
                    0:       qd = 0;
                    1:       qd = 1;
                    2:       qd = 2;
                    default: qd = rand_word();
                endcase
                an = ($urandom_range(0, 1) == 0) ? 16'h0 : rand_word();
                ns = ($urandom_range(0, 1) == 0) ? 16'h0 : rand_word();
                build_query(rand_word(), rand_word(), qd, an, ns, $urandom_range(0, 3), 10,
                            rand_word(), rand_word(), $urandom_range(0, 3));
                queue_message(msg_bytes.size(), 0);
            end
            else if (kind == 7)
            begin
                build_query(rand_word(), rand_word(), 1, 0, 0, $urandom_range(0, 3), 10,
                            rand_word(), rand_word(), 0);
                queue_message(msg_bytes.size(), $urandom_range(1, msg_bytes.size()));
            end
            else if (kind == 8)
            begin
                build_query(rand_word(), rand_word(), 1, 0, 0, $urandom_range(0, 4), 20,
                            rand_word(), rand_word(), $urandom_range(0, 3));
                queue_message($urandom_range(0, HEADER_BYTES - 1), 0);
            end
            else
            begin
                repeat ($urandom_range(1, 40))
                    msg_bytes.push_back(8'($urandom_range(0, 255)));
                queue_message($urandom_range(0, 65535), 0);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d messages, directed cases then random well-formed,",
                 queued_items, messages_queued);
        $display("broken and noise queries; checked %0d name characters, %0d final records",
                 chars_seen, records_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // input side: hold a stalled transfer, idle in bursts until the late part of the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_valid <= 1'b0;
            query       <= '0;
            send_idle   <= 0;
        end
        else
        begin
            if (query_valid && !query_stall)
            begin
                decode_byte(query);
                void'(pending_bytes.pop_front());
            end
            if (!(query_valid && query_stall))
            begin
                if (send_idle > 0)
                begin
                    send_idle   <= send_idle - 1;
                    query_valid <= 1'b0;
                end
                else if (pending_bytes.size() > CALM_ITEMS && $urandom_range(0, 9) == 0)
                begin
                    send_idle   <= $urandom_range(0, 15);
                    query_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    query_valid <= 1'b1;
                    query       <= pending_bytes[0];
                end
                else
                    query_valid <= 1'b0;
            end
        end
    end

    // output side: check each transfer against the oldest expected result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_idle    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", 16'(result.out_kind),
                                    16'h0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.out_kind !== want.out_kind)
                        report_mismatch("out_kind", 16'(result.out_kind),
                                        16'(want.out_kind));
                    if (result.name_char !== want.name_char)
                        report_mismatch("name_char", 16'(result.name_char),
                                        16'(want.name_char));
                    if (result.status !== want.status)
                        report_mismatch("status", 16'(result.status), 16'(want.status));
                    if (result.query_id !== want.query_id)
                        report_mismatch("query_id", result.query_id, want.query_id);
                    if (result.header_flags !== want.header_flags)
                        report_mismatch("header_flags", result.header_flags, want.header_flags);
                    if (result.question_type !== want.question_type)
                        report_mismatch("question_type", result.question_type,
                                        want.question_type);
                    if (result.question_class !== want.question_class)
                        report_mismatch("question_class", result.question_class,
                                        want.question_class);
                    if (want.out_kind == KIND_RECORD)
                        records_seen++;
                    else
                        chars_seen++;
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle    <= recv_idle - 1;
                result_stall <= 1'b1;
            end
            else if (pending_bytes.size() > CALM_ITEMS && $urandom_range(0, 9) == 0)
            begin
                recv_idle    <= $urandom_range(0, 15);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("timeout with %0d bytes pending and %0d results outstanding",
                 pending_bytes.size(), expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
